// ===== hw/rtl/hefe_pkg.sv =====
package hefe_pkg;

    // Validity limits on the event fields.
    localparam int unsigned SCOPE_LIMIT      = 16;
    localparam int unsigned CLASS_LIMIT      = 16;
    localparam int unsigned STATE_LIMIT      = 16;
    localparam int unsigned URGENCY_LIMIT    = 16;
    localparam int unsigned DATA_CODE_LIMIT  = 256;
    localparam int unsigned CODEBOOK_ENTRIES = 16;

    // The profile holds sync, mark and end ids and then the codebook entries.
    localparam int unsigned PROFILE_IDS = 3 + CODEBOOK_ENTRIES;

    localparam logic [7:0] CK_SEED     = 8'h5a;
    localparam logic [7:0] EVENT_VER   = 8'd1;
    localparam logic [7:0] PROFILE_FMT = 8'd1;

    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned SLOT_W      = 3;

    // Slot positions within a good event's frame.
    localparam logic [SLOT_W-1:0] SLOT_SYNC    = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_SCOPE   = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_CLASS   = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_STATE   = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_URGENCY = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_END     = 3'd5;

    typedef enum logic [1:0] {
        KIND_SYNC = 2'd0,
        KIND_CODE = 2'd1,
        KIND_END  = 2'd2
    } t_slot_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FORMAT   = 2'd1,
        ST_PROFILE  = 2'd2,
        ST_FRAGMENT = 2'd3
    } t_status;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ACTUATOR_TYPE    = 4'd0,
        CFG_PROFILE_FORMAT   = 4'd1,
        CFG_PROFILE_REVISION = 4'd2,
        CFG_SYNC_EFFECT      = 4'd3,
        CFG_MARK_EFFECT      = 4'd4,
        CFG_END_EFFECT       = 4'd5,
        CFG_CODEBOOK_LOW     = 4'd6,
        CFG_CODEBOOK_HIGH    = 4'd7
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] event_version;
        logic [7:0] scope;
        logic [7:0] class_value;
        logic [7:0] state_value;
        logic [7:0] urgency;
        logic [7:0] data_flag;
        logic [7:0] data_value;
        logic [7:0] frag_idx;
        logic [7:0] frag_count;
    } t_event_in;

    typedef struct packed {
        t_slot_kind slot_kind;
        logic [3:0] slot_code;
        logic [7:0] effect_num;
        t_status    status;
        logic [7:0] checksum;
        logic       last;
    } t_slot_out;

endpackage

// ===== hw/rtl/haptic_event_frame_encoder.sv =====
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_stall      i_in_data   (t_event_in)
// output    out        o_out_valid / i_out_stall    o_out_data  (t_slot_out)
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A good event gives six slot transactions, one per cycle while the output is
// not stalled; an event that fails a check gives one result. The slot counter
// on the input register steps through the slots of the event that it holds,
// and each slot passes from that register into the output register.
// Reset is synchronous and active low; it restores the default profile.
// A downstream stall holds the output register and, once the input register
// has its next slot waiting, holds off new events as well.
module haptic_event_frame_encoder
    import hefe_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_event_in              i_in_data,

    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_slot_out              o_out_data,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [63:0]            i_cfg_data
);

    // Profile registers. The actuator kind does not affect the encoding, so a
    // write to it is taken but not stored.
    logic [7:0]  r_profile_format;
    logic [7:0]  r_profile_revision;
    logic [7:0]  r_sync_effect;
    logic [7:0]  r_mark_effect;
    logic [7:0]  r_end_effect;
    logic [63:0] r_codebook_low;
    logic [63:0] r_codebook_high;
    logic        r_profile_ok;
    logic        n_profile_ok;

    // Input register holding the event that is being framed.
    t_event_in         r_in;
    logic              r_in_vld;
    logic [SLOT_W-1:0] r_slot;
    t_event_in         n_in;
    logic              n_in_vld;
    logic [SLOT_W-1:0] n_slot;

    // Output register.
    t_slot_out r_out;
    logic      r_out_vld;
    t_slot_out n_out;
    logic      n_out_vld;

    logic       out_free;
    logic       advance;
    logic       in_ready;
    logic       in_take;
    logic       event_ok;
    logic       fragment_err;
    logic       frame_last;
    logic [3:0] code_sel;
    logic [7:0] book [CODEBOOK_ENTRIES];
    logic [7:0] ids  [PROFILE_IDS];
    t_slot_out  slot;

    // The checksum is a linear mix of the nine bytes: XOR in, rotate left.
    function automatic logic [7:0] event_checksum(input t_event_in ev);
        logic [7:0]            c;
        logic [9*8-1:0]        bytes;
        c     = CK_SEED;
        bytes = ev;
        for (int i = 0; i < 9; i++) begin
            c = c ^ bytes[(8-i)*8 +: 8];
            c = {c[6:0], c[7]};
        end
        return c;
    endfunction

    // -----------------------------------------------------------------
    // Configuration port. The user must write only while the block is idle; the
    // block itself does not enforce this. The profile check is registered into
    // r_profile_ok in the cycle after a write lands in the profile registers.
    // -----------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_profile_format   <= 8'd1;
            r_profile_revision <= 8'd1;
            r_sync_effect      <= 8'd1;
            r_mark_effect      <= 8'd2;
            r_end_effect       <= 8'd3;
            r_codebook_low     <= '0;
            r_codebook_high    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PROFILE_FORMAT:   r_profile_format   <= i_cfg_data[7:0];
                CFG_PROFILE_REVISION: r_profile_revision <= i_cfg_data[7:0];
                CFG_SYNC_EFFECT:      r_sync_effect      <= i_cfg_data[7:0];
                CFG_MARK_EFFECT:      r_mark_effect      <= i_cfg_data[7:0];
                CFG_END_EFFECT:       r_end_effect       <= i_cfg_data[7:0];
                CFG_CODEBOOK_LOW:     r_codebook_low     <= i_cfg_data;
                CFG_CODEBOOK_HIGH:    r_codebook_high    <= i_cfg_data;
                default: begin
                    // Actuator kind and indexes beyond the list are ignored.
                end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            book[i]     = r_codebook_low[i*8 +: 8];
            book[i + 8] = r_codebook_high[i*8 +: 8];
        end
        ids[0] = r_sync_effect;
        ids[1] = r_mark_effect;
        ids[2] = r_end_effect;
        for (int i = 0; i < CODEBOOK_ENTRIES; i++) begin
            ids[3 + i] = book[i];
        end
        // Every id nonzero, and no two ids alike: one flat layer of compares.
        n_profile_ok = (r_profile_format == PROFILE_FMT) && (r_profile_revision != 8'd0);
        for (int i = 0; i < PROFILE_IDS; i++) begin
            if (ids[i] == 8'd0) begin
                n_profile_ok = 1'b0;
            end
            for (int j = 0; j < i; j++) begin
                if (ids[i] == ids[j]) begin
                    n_profile_ok = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_profile_ok <= 1'b0;
        end else begin
            r_profile_ok <= n_profile_ok;
        end
    end

    // -----------------------------------------------------------------
    // Event checks on the input register.
    // -----------------------------------------------------------------
    always_comb begin
        event_ok = (r_in.event_version == EVENT_VER)
                && ({1'b0, r_in.scope}       < 9'(SCOPE_LIMIT))
                && ({1'b0, r_in.class_value} < 9'(CLASS_LIMIT))
                && ({1'b0, r_in.state_value} < 9'(STATE_LIMIT))
                && ({1'b0, r_in.urgency}     < 9'(URGENCY_LIMIT))
                && (r_in.data_flag <= 8'd1)
                && (r_in.frag_count != 8'd0)
                && (r_in.frag_idx < r_in.frag_count)
                && ((r_in.data_flag == 8'd0)
                    || ({1'b0, r_in.data_value} < 9'(DATA_CODE_LIMIT)));
        // Only a plain single fragment without data is framed.
        fragment_err = (r_in.data_flag != 8'd0) || (r_in.frag_count > 8'd1);
    end

    // -----------------------------------------------------------------
    // Slot selection. A failing event gives a single error result; a good
    // one steps through sync, four code slots and the end slot.
    // -----------------------------------------------------------------
    always_comb begin
        case (r_slot)
            SLOT_SCOPE:   code_sel = r_in.scope[3:0];
            SLOT_CLASS:   code_sel = r_in.class_value[3:0];
            SLOT_STATE:   code_sel = r_in.state_value[3:0];
            SLOT_URGENCY: code_sel = r_in.urgency[3:0];
            default:      code_sel = 4'd0;
        endcase

        slot.slot_kind  = KIND_SYNC;
        slot.slot_code  = 4'd0;
        slot.effect_num = 8'd0;
        slot.status     = ST_OK;
        slot.checksum   = 8'd0;
        slot.last       = 1'b1;

        if (!event_ok) begin
            slot.status = ST_FORMAT;
        end else if (!r_profile_ok) begin
            slot.status = ST_PROFILE;
        end else if (fragment_err) begin
            slot.status = ST_FRAGMENT;
        end else begin
            case (r_slot)
                SLOT_SYNC: begin
                    slot.effect_num = r_sync_effect;
                    slot.last       = 1'b0;
                end
                SLOT_SCOPE, SLOT_CLASS, SLOT_STATE, SLOT_URGENCY: begin
                    slot.slot_kind  = KIND_CODE;
                    slot.slot_code  = code_sel;
                    slot.effect_num = book[code_sel];
                    slot.last       = 1'b0;
                end
                SLOT_END: begin
                    slot.slot_kind  = KIND_END;
                    slot.effect_num = r_end_effect;
                    slot.checksum   = event_checksum(r_in);
                end
                default: begin
                    slot.last = 1'b1;
                end
            endcase
        end
        frame_last = slot.last;
    end

    // -----------------------------------------------------------------
    // Handshake and sequencing. The output register frees when its slot is
    // taken; a new event enters as the current one moves its last slot out,
    // so the final result may still be waiting while the next event loads.
    // -----------------------------------------------------------------
    assign out_free   = !r_out_vld || !i_out_stall;
    assign advance    = r_in_vld && out_free;
    assign in_ready   = !r_in_vld || (advance && frame_last);
    assign in_take    = i_in_valid && in_ready;
    assign o_in_stall = !in_ready;

    always_comb begin
        n_in      = r_in;
        n_in_vld  = r_in_vld;
        n_slot    = r_slot;
        n_out     = r_out;
        n_out_vld = r_out_vld;

        if (advance) begin
            n_out     = slot;
            n_out_vld = 1'b1;
            if (frame_last) begin
                n_in_vld = 1'b0;
                n_slot   = SLOT_SYNC;
            end else begin
                n_slot = r_slot + SLOT_W'(1);
            end
        end else if (out_free) begin
            n_out_vld = 1'b0;
        end

        if (in_take) begin
            n_in     = i_in_data;
            n_in_vld = 1'b1;
            n_slot   = SLOT_SYNC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_slot    <= SLOT_SYNC;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_slot    <= n_slot;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // -----------------------------------------------------------------
    // Assertions.
    // -----------------------------------------------------------------
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_END)
        else $error("slot counter beyond the end slot");

    a_take_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_in_vld && r_slot == SLOT_SYNC))
        else $error("accepted event did not start at the sync slot");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK)
            |-> (o_out_data.last && o_out_data.effect_num == 8'd0))
        else $error("error result is not a single closing result");

    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_OK && o_out_data.last)
            |-> (o_out_data.slot_kind == KIND_END))
        else $error("good frame closed on a slot other than end");

    a_code_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_slot != SLOT_SYNC) |-> $past(r_in_vld))
        else $error("slot advanced without a held event");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import hefe_pkg::*;

    // A slot frame can be held up by a long downstream stall on every slot,
    // so the limit is set well above the slowest plausible run.
    localparam int unsigned CLK_PERIOD  = 20;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RESET_CYCLES = 6;
    localparam int unsigned SETTLE_CYCLES = 8;

    // Mirror of the profile registers, kept in one packed record so that a
    // whole profile can be built, altered and written back in one go.
    typedef struct packed {
        logic       actuator;
        logic [7:0] fmt;
        logic [7:0] rev;
        logic [7:0] sync_id;
        logic [7:0] mark_id;
        logic [7:0] end_id;
        logic [63:0] book_lo;
        logic [63:0] book_hi;
    } t_profile_regs;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    t_event_in              i_in_data   = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b1;
    t_slot_out              o_out_data;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [63:0]            i_cfg_data  = '0;

    // Predictor state: the registers as the block should hold them, and the
    // slots still owed by the block, oldest first.
    t_profile_regs live_profile;
    t_slot_out     expected_slots[$];

    int unsigned cycle_count = 0;
    int unsigned mismatches  = 0;
    int unsigned gap_pct     = 0;
    int unsigned stall_pct   = 0;
    int unsigned stall_left  = 0;
    t_slot_out   owed_slot;

    haptic_event_frame_encoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Codebook entry idx of a profile; the index is already four bits wide.
    function automatic logic [7:0] book_id(t_profile_regs p, logic [3:0] idx);
        if (idx < 4'd8) begin
            return p.book_lo[8 * idx +: 8];
        end
        return p.book_hi[8 * (idx - 4'd8) +: 8];
    endfunction

    // The event check covers the version, the four coded fields against
    // their limits, the data flag, the fragment pair and, when data is
    // present, the data code.
    function automatic bit event_ok(t_event_in ev);
        if (ev.event_version != EVENT_VER || ev.scope >= SCOPE_LIMIT ||
            ev.class_value >= CLASS_LIMIT || ev.state_value >= STATE_LIMIT ||
            ev.urgency >= URGENCY_LIMIT || ev.data_flag > 8'd1 ||
            ev.frag_count == 8'd0 || ev.frag_idx >= ev.frag_count) begin
            return 1'b0;
        end
        if (ev.data_flag != 8'd0 && ev.data_value >= DATA_CODE_LIMIT) begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // A usable profile has the right format, a nonzero revision, and all
    // nineteen effect ids nonzero and different from one another.
    function automatic bit profile_ok(t_profile_regs p);
        logic [7:0] ids [PROFILE_IDS];
        if (p.fmt != PROFILE_FMT || p.rev == 8'd0) begin
            return 1'b0;
        end
        ids[0] = p.sync_id;
        ids[1] = p.mark_id;
        ids[2] = p.end_id;
        for (int i = 0; i < CODEBOOK_ENTRIES; i++) begin
            ids[3 + i] = book_id(p, i[3:0]);
        end
        for (int i = 0; i < PROFILE_IDS; i++) begin
            if (ids[i] == 8'd0) begin
                return 1'b0;
            end
            for (int j = 0; j < i; j++) begin
                if (ids[i] == ids[j]) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // Each of the nine event bytes, in field order, is folded in by XOR and
    // the running value is then rotated left by one bit.
    function automatic logic [7:0] fold_checksum(t_event_in ev);
        logic [71:0] raw;
        logic [7:0]  sum;
        raw = ev;
        sum = CK_SEED;
        for (int i = 0; i < 9; i++) begin
            sum = sum ^ raw[71 - 8 * i -: 8];
            sum = {sum[6:0], sum[7]};
        end
        return sum;
    endfunction

    // Queues the slots that one accepted event should give. A failed check
    // gives a lone result carrying only its status; otherwise the frame is
    // SYNC, four CODE slots and END.
    function automatic void predict_frame(t_event_in ev);
        t_slot_out  s;
        logic [7:0] coded [4];
        s = '0;
        s.last = 1'b1;
        if (!event_ok(ev)) begin
            s.status = ST_FORMAT;
            expected_slots.push_back(s);
        end else if (!profile_ok(live_profile)) begin
            s.status = ST_PROFILE;
            expected_slots.push_back(s);
        end else if (ev.data_flag != 8'd0 || ev.frag_count > 8'd1) begin
            s.status = ST_FRAGMENT;
            expected_slots.push_back(s);
        end else begin
            coded[0] = ev.scope;
            coded[1] = ev.class_value;
            coded[2] = ev.state_value;
            coded[3] = ev.urgency;
            s = '0;
            s.slot_kind  = KIND_SYNC;
            s.effect_num = live_profile.sync_id;
            expected_slots.push_back(s);
            for (int i = 0; i < 4; i++) begin
                s = '0;
                s.slot_kind  = KIND_CODE;
                s.slot_code  = coded[i][3:0];
                s.effect_num = book_id(live_profile, coded[i][3:0]);
                expected_slots.push_back(s);
            end
            s = '0;
            s.slot_kind  = KIND_END;
            s.effect_num = live_profile.end_id;
            s.checksum   = fold_checksum(ev);
            s.last       = 1'b1;
            expected_slots.push_back(s);
        end
    endfunction

    // Register writes land in the mirror exactly as the block should take
    // them: narrow registers keep their low bits, unlisted indexes are dropped.
    function automatic void store_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] value);
        case (idx)
            CFG_ACTUATOR_TYPE:    live_profile.actuator = value[0];
            CFG_PROFILE_FORMAT:   live_profile.fmt      = value[7:0];
            CFG_PROFILE_REVISION: live_profile.rev      = value[7:0];
            CFG_SYNC_EFFECT:      live_profile.sync_id  = value[7:0];
            CFG_MARK_EFFECT:      live_profile.mark_id  = value[7:0];
            CFG_END_EFFECT:       live_profile.end_id   = value[7:0];
            CFG_CODEBOOK_LOW:     live_profile.book_lo  = value;
            CFG_CODEBOOK_HIGH:    live_profile.book_hi  = value;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Length of an idle stretch: usually none, now and then a short one,
    // and rarely a long one.
    function automatic int unsigned draw_gap(int unsigned pct);
        if ($urandom_range(99, 0) < pct) begin
            return ($urandom_range(9, 0) == 0) ? $urandom_range(30, 8) : $urandom_range(3, 1);
        end
        return 0;
    endfunction

    function automatic t_event_in build_event(
        logic [7:0] ver, logic [7:0] sc, logic [7:0] cl, logic [7:0] st, logic [7:0] ur,
        logic [7:0] hd, logic [7:0] dv, logic [7:0] fi, logic [7:0] ft);
        t_event_in ev;
        ev.event_version = ver;
        ev.scope         = sc;
        ev.class_value   = cl;
        ev.state_value   = st;
        ev.urgency       = ur;
        ev.data_flag     = hd;
        ev.data_value    = dv;
        ev.frag_idx      = fi;
        ev.frag_count    = ft;
        return ev;
    endfunction

    // A random profile that passes every check. With extremes set, the
    // smallest and largest ids both appear at random places in it.
    function automatic t_profile_regs draw_profile(bit extremes);
        t_profile_regs p;
        logic [7:0]    ids [PROFILE_IDS];
        bit            taken [256];
        int            hi_pos;
        int            lo_pos;
        logic [7:0]    cand;
        hi_pos = -1;
        lo_pos = -1;
        foreach (taken[i]) begin
            taken[i] = 1'b0;
        end
        taken[0] = 1'b1;
        if (extremes) begin
            hi_pos = $urandom_range(PROFILE_IDS - 1, 0);
            lo_pos = (hi_pos + 1 + $urandom_range(PROFILE_IDS - 2, 0)) % PROFILE_IDS;
            ids[hi_pos] = 8'hff;
            ids[lo_pos] = 8'h01;
            taken[255]  = 1'b1;
            taken[1]    = 1'b1;
        end
        for (int i = 0; i < PROFILE_IDS; i++) begin
            if (i != hi_pos && i != lo_pos) begin
                do begin
                    cand = 8'($urandom_range(255, 1));
                end while (taken[cand]);
                taken[cand] = 1'b1;
                ids[i] = cand;
            end
        end
        p.actuator = 1'($urandom_range(1, 0));
        p.fmt      = PROFILE_FMT;
        p.rev      = extremes ? 8'hff : 8'($urandom_range(255, 1));
        p.sync_id  = ids[0];
        p.mark_id  = ids[1];
        p.end_id   = ids[2];
        for (int i = 0; i < CODEBOOK_ENTRIES; i++) begin
            if (i < 8) begin
                p.book_lo[8 * i +: 8] = ids[3 + i];
            end else begin
                p.book_hi[8 * (i - 8) +: 8] = ids[3 + i];
            end
        end
        return p;
    endfunction

    // One input transaction. Valid is raised at a falling edge, after an
    // optional idle stretch, and the event is predicted at the rising edge
    // that accepts it. Valid is left high on return; the next call, or the
    // drain, decides at the following falling edge what it carries.
    task automatic send_event(t_event_in ev);
        int unsigned gap;
        gap = draw_gap(gap_pct);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        predict_frame(ev);
    endtask

    // Drops valid and waits until every owed slot has come out, then lets the
    // block settle so that it is surely quiet.
    task automatic drain_events();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_slots.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One configuration transaction; the mirror is updated at the edge that
    // takes the write. Valid stays high for a following write.
    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [63:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        store_reg(idx, value);
    endtask

    // Writes every register of the profile. Narrow registers get random
    // bits above their width, which the block must ignore. With stray set, a
    // write to an index past the register list follows and must change
    // nothing.
    task automatic apply_profile(t_profile_regs p, bit stray);
        logic [63:0] noise;
        logic [CFG_INDEX_W-1:0] spare_idx;
        noise = {$urandom, $urandom};
        cfg_write(CFG_ACTUATOR_TYPE,    {noise[63:1], p.actuator});
        cfg_write(CFG_PROFILE_FORMAT,   {noise[63:8], p.fmt});
        cfg_write(CFG_PROFILE_REVISION, {noise[63:8], p.rev});
        cfg_write(CFG_SYNC_EFFECT,      {noise[63:8], p.sync_id});
        cfg_write(CFG_MARK_EFFECT,      {noise[63:8], p.mark_id});
        cfg_write(CFG_END_EFFECT,       {noise[63:8], p.end_id});
        cfg_write(CFG_CODEBOOK_LOW,     p.book_lo);
        cfg_write(CFG_CODEBOOK_HIGH,    p.book_hi);
        if (stray) begin
            spare_idx = CFG_INDEX_W'(CFG_CODEBOOK_HIGH + 1 + $urandom_range(6, 0));
            cfg_write(spare_idx, {$urandom, $urandom});
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Downstream stall pattern, changed only at falling edges.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = draw_gap(stall_pct);
        end
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch in %s: got 0x%0h, expected 0x%0h (cycle %0d)",
                 what, got, want, cycle_count);
        mismatches++;
    endtask

    // Every output transaction is matched against the oldest owed slot,
    // one field at a time.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_slots.size() == 0) begin
                flag_mismatch("slot with nothing owed", o_out_data, 0);
            end else begin
                owed_slot = expected_slots.pop_front();
                if (o_out_data.slot_kind !== owed_slot.slot_kind) begin
                    flag_mismatch("slot_kind", o_out_data.slot_kind, owed_slot.slot_kind);
                end
                if (o_out_data.slot_code !== owed_slot.slot_code) begin
                    flag_mismatch("slot_code", o_out_data.slot_code, owed_slot.slot_code);
                end
                if (o_out_data.effect_num !== owed_slot.effect_num) begin
                    flag_mismatch("effect_num", o_out_data.effect_num, owed_slot.effect_num);
                end
                if (o_out_data.status !== owed_slot.status) begin
                    flag_mismatch("status", o_out_data.status, owed_slot.status);
                end
                if (o_out_data.checksum !== owed_slot.checksum) begin
                    flag_mismatch("checksum", o_out_data.checksum, owed_slot.checksum);
                end
                if (o_out_data.last !== owed_slot.last) begin
                    flag_mismatch("last", o_out_data.last, owed_slot.last);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d slots still owed",
                     cycle_count, expected_slots.size());
            $display("[haptic_event_frame_encoder] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset the codebook is all zero, so the profile is
    // unusable: good events are refused with a profile error, while a bad
    // event still reports its format error first.
    task automatic test_reset_profile();
        gap_pct   = 20;
        stall_pct = 20;
        send_event(build_event(8'd1, 8'd3, 8'd4, 8'd5, 8'd6, 8'd0, 8'd0, 8'd0, 8'd1));
        send_event(build_event(8'd0, 8'd3, 8'd4, 8'd5, 8'd6, 8'd0, 8'd0, 8'd0, 8'd1));
        send_event(build_event(8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd7, 8'd0, 8'd1));
        drain_events();
    endtask

    // Field extremes against a usable profile: each limit, the data flag,
    // the fragment pair, and events that pass the format check but are not
    // plain single fragments.
    task automatic test_event_fields();
        apply_profile(draw_profile(1'b1), 1'b0);
        gap_pct   = 25;
        stall_pct = 25;
        send_event(build_event(8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1));
        send_event(build_event(8'd1, 8'd15, 8'd15, 8'd15, 8'd15, 8'd0, 8'd255, 8'd0, 8'd1));
        send_event(build_event(8'd1, 8'd10, 8'd5, 8'd12, 8'd3, 8'd0, 8'd170, 8'd0, 8'd1));
        send_event(build_event(8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 8'd0, 8'd0, 8'd1));
        send_event(build_event(8'd255, 8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 8'd0, 8'd0, 8'd1));
        send_event(build_event(8'd2, 8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 8'd0, 8'd0, 8'd1));
        send_event(build_event(8'd1, 8'd16, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1));
        send_event(build_event(8'd1, 8'd0, 8'd16, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1));
        send_event(build_event(8'd1, 8'd0, 8'd0, 8'd16, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1));
        send_event(build_event(8'd1, 8'd0, 8'd0, 8'd0, 8'd16, 8'd0, 8'd0, 8'd0, 8'd1));
        send_event(build_event(8'd1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd1));
        send_event(build_event(8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd0, 8'd0, 8'd1));
        send_event(build_event(8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd255, 8'd0, 8'd0, 8'd1));
        send_event(build_event(8'd1, 8'd7, 8'd8, 8'd9, 8'd1, 8'd1, 8'd255, 8'd0, 8'd1));
        send_event(build_event(8'd1, 8'd7, 8'd8, 8'd9, 8'd1, 8'd1, 8'd0, 8'd0, 8'd1));
        send_event(build_event(8'd1, 8'd4, 8'd4, 8'd4, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0));
        send_event(build_event(8'd1, 8'd4, 8'd4, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'd1));
        send_event(build_event(8'd1, 8'd4, 8'd4, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'd2));
        send_event(build_event(8'd1, 8'd4, 8'd4, 8'd4, 8'd4, 8'd0, 8'd0, 8'd0, 8'd255));
        send_event(build_event(8'd1, 8'd4, 8'd4, 8'd4, 8'd4, 8'd0, 8'd0, 8'd254, 8'd255));
        send_event(build_event(8'd1, 8'd4, 8'd4, 8'd4, 8'd4, 8'd0, 8'd0, 8'd255, 8'd255));
        drain_events();
    endtask

    // Each way of spoiling a profile in turn, then a clean profile with the
    // largest revision and a write to an unlisted index. Against a spoiled
    // profile a good event and a fragment both give a profile error, as that
    // check comes before the fragment check.
    task automatic test_profile_checks();
        t_profile_regs good;
        t_profile_regs spoilt;
        good = draw_profile(1'b0);
        gap_pct   = 15;
        stall_pct = 15;
        for (int variant = 0; variant < 10; variant++) begin
            spoilt = good;
            case (variant)
                0: spoilt.fmt = 8'd0;
                1: spoilt.fmt = 8'd255;
                2: spoilt.rev = 8'd0;
                3: spoilt.sync_id = 8'd0;
                4: spoilt.mark_id = spoilt.sync_id;
                5: spoilt.end_id = spoilt.book_lo[15:8];
                6: spoilt.book_hi[63:56] = spoilt.book_lo[7:0];
                7: spoilt.book_lo[63:56] = 8'd0;
                8: spoilt.book_hi[7:0] = 8'd0;
                default: spoilt.book_hi[23:16] = spoilt.book_hi[15:8];
            endcase
            apply_profile(spoilt, 1'b0);
            send_event(build_event(8'd1, 8'd1, 8'd9, 8'd14, 8'd15, 8'd0, 8'd0, 8'd0, 8'd1));
            send_event(build_event(8'd3, 8'd1, 8'd9, 8'd14, 8'd15, 8'd0, 8'd0, 8'd0, 8'd1));
            send_event(build_event(8'd1, 8'd1, 8'd9, 8'd14, 8'd15, 8'd0, 8'd0, 8'd1, 8'd3));
            drain_events();
        end
        good.rev      = 8'hff;
        good.actuator = 1'b1;
        apply_profile(good, 1'b1);
        send_event(build_event(8'd1, 8'd11, 8'd6, 8'd13, 8'd8, 8'd0, 8'd0, 8'd0, 8'd1));
        drain_events();
    endtask

    // Random traffic over several profiles and idling patterns. Most events
    // are well formed with random content so that full frames dominate; the
    // rest are valid fragments, events with one field broken, and noise.
    task automatic test_random_traffic();
        t_event_in   ev;
        int unsigned pick;
        for (int phase = 0; phase < 4; phase++) begin
            apply_profile(draw_profile(phase[0]), 1'b0);
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 30; stall_pct = 30; end
                2: begin gap_pct = 10; stall_pct = 60; end
                default: begin gap_pct = 50; stall_pct = 10; end
            endcase
            for (int n = 0; n < 16; n++) begin
                pick = $urandom_range(99, 0);
                ev = build_event(EVENT_VER, 8'($urandom_range(15, 0)),
                                 8'($urandom_range(15, 0)), 8'($urandom_range(15, 0)),
                                 8'($urandom_range(15, 0)), 8'd0,
                                 8'($urandom_range(255, 0)), 8'd0, 8'd1);
                if (pick >= 60 && pick < 70) begin
                    // A legal event that is part of a longer message.
                    ev.data_flag  = 8'($urandom_range(1, 0));
                    ev.frag_count = 8'($urandom_range(255, 2));
                    ev.frag_idx   = 8'($urandom_range(ev.frag_count - 1, 0));
                end else if (pick >= 70 && pick < 85) begin
                    // One field pushed outside its range.
                    case ($urandom_range(6, 0))
                        0: ev.event_version = 8'($urandom_range(255, 2));
                        1: ev.scope         = 8'($urandom_range(255, SCOPE_LIMIT));
                        2: ev.class_value   = 8'($urandom_range(255, CLASS_LIMIT));
                        3: ev.state_value   = 8'($urandom_range(255, STATE_LIMIT));
                        4: ev.urgency       = 8'($urandom_range(255, URGENCY_LIMIT));
                        5: ev.data_flag     = 8'($urandom_range(255, 2));
                        default: ev.frag_idx = 8'($urandom_range(255, 1));
                    endcase
                end else if (pick >= 85) begin
                    ev = t_event_in'({$urandom, $urandom, 8'($urandom)});
                end
                send_event(ev);
            end
            drain_events();
        end
    endtask

    initial begin
        live_profile          = '0;
        live_profile.fmt      = PROFILE_FMT;
        live_profile.rev      = 8'd1;
        live_profile.sync_id  = 8'd1;
        live_profile.mark_id  = 8'd2;
        live_profile.end_id   = 8'd3;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_profile();
        test_event_fields();
        test_profile_checks();
        test_random_traffic();

        drain_events();
        if (mismatches == 0 && expected_slots.size() == 0) begin
            $display("[haptic_event_frame_encoder] OK");
        end else begin
            $display("[haptic_event_frame_encoder] ERROR");
        end
        $finish;
    end

endmodule
